@@ rtl/core/kde_pkg.sv @@
package kde_pkg;

	// Item geometry
	localparam int NUM_COORDS = 4;
	localparam int MAX_DIMS   = 4;
	localparam int COORD_W    = 16;
	localparam int POINT_W    = NUM_COORDS * COORD_W;

	// Point store
	localparam int MAX_POINTS = 256;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Datapath widths
	localparam int SQ_W     = 2 * COORD_W;
	localparam int DSQ_W    = SQ_W + $clog2(NUM_COORDS);
	localparam int THRESH_W = 35;
	localparam int HIV_W    = 32;
	localparam int NORM_W   = 32;
	localparam int PHI_W    = (DSQ_W - 16) + HIV_W;
	localparam int PLO_W    = 16 + HIV_W;
	localparam int T_W      = PHI_W + 1;
	localparam int EXP_W    = 16;
	localparam int SUM_W    = EXP_W + IDX_W;
	localparam int PROD_W   = SUM_W + NORM_W;
	localparam int DENS_W   = 48;
	localparam int DIMS_W   = 3;
	localparam int STAT_W   = 2;

	// Exp table over t in [0,8), t in Q.16
	localparam int EXP_ENTRIES  = 1024;
	localparam int EXP_AW       = $clog2(EXP_ENTRIES);
	localparam int SERIES_TERMS = 24;
	localparam logic [T_W-1:0] T_LIMIT = T_W'(8 << 16);

	// Operation codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_DIMS   = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;
	localparam logic [1:0] REG_HIV    = 2'd2;
	localparam logic [1:0] REG_NORM   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SCALE,
		ST_LAUNCH,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef logic [NUM_COORDS-1:0][SQ_W-1:0] lane_sq_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] hits;
		logic [SUM_W-1:0] sum;
	} merge_out_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
	} div_out_t;

	typedef logic [EXP_ENTRIES-1:0][EXP_W-1:0] exp_rom_t;

	// exp(-f) in Q.32 for f < 1.0, alternating series with truncation
	function automatic logic [63:0] exp_frac_q32(input logic [63:0] f);
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] term;
		pos  = 64'd1 << 32;
		neg  = 64'd0;
		term = 64'd1 << 32;
		for (int k = 1; k <= SERIES_TERMS; k++) begin
			term = ((term * f) >> 32) / 64'(k);
			if (k % 2 == 1)
				neg = neg + term;
			else
				pos = pos + term;
		end
		return (pos >= neg) ? pos - neg : 64'd0;
	endfunction

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] half;
		logic [63:0] e1;
		logic [63:0] t;
		logic [63:0] whole;
		logic [63:0] r;
		logic [63:0] v;
		half = exp_frac_q32(64'h0000_0000_8000_0000);
		e1   = (half * half) >> 32;
		for (int k = 0; k < EXP_ENTRIES; k++) begin
			t     = (64'(k) << 35) / 64'(EXP_ENTRIES);
			whole = t >> 32;
			r     = exp_frac_q32(t & 64'h0000_0000_FFFF_FFFF);
			for (int w = 0; w < 8; w++) begin
				if (64'(w) < whole)
					r = (r * e1) >> 32;
			end
			v = (r + 64'h8000) >> 16;
			rom[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ rtl/core/kde_lane.sv @@
module kde_lane (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [kde_pkg::COORD_W-1:0] x,
	input  logic signed [kde_pkg::COORD_W-1:0] p,
	output logic [kde_pkg::SQ_W-1:0]   sq_s2
);
	import kde_pkg::*;

	logic signed [COORD_W:0] diff;
	logic [COORD_W-1:0]      mag;

	// Take the absolute coordinate difference
	assign diff = (COORD_W+1)'(x) - (COORD_W+1)'(p);
	assign mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

	// Square it, or drop the lane when the coordinate does not count
	always_ff @(posedge clk) begin
		sq_s2 <= en ? SQ_W'(mag) * SQ_W'(mag) : '0;
	end

endmodule

@@ rtl/core/kde_merge.sv @@
module kde_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             v_s2,
	input  kde_pkg::lane_sq_t                sq_s2,
	input  logic [kde_pkg::THRESH_W-1:0]     thresh,
	input  logic [kde_pkg::HIV_W-1:0]        hiv,
	output kde_pkg::merge_out_t              mo
);
	import kde_pkg::*;

	logic [DSQ_W-1:0]  dsq_c;
	logic [DSQ_W-1:0]  dsq_s3;
	logic              v_s3;
	logic [PHI_W-1:0]  phi_s4;
	logic [PLO_W-1:0]  plo_s4;
	logic              in_s4;
	logic              v_s4;
	logic [T_W-1:0]    t_c;
	logic [EXP_W-1:0]  rom_s5;
	logic              add_s5;
	logic              win_s5;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  within_q;

	// Combine the lanes into the squared distance
	always_comb begin
		dsq_c = '0;
		for (int l = 0; l < NUM_COORDS; l++)
			dsq_c = dsq_c + DSQ_W'(sq_s2[l]);
	end

	assign t_c = T_W'(phi_s4) + T_W'(plo_s4[PLO_W-1:16]);

	// Stage registers: distance, products, threshold compare, table read
	always_ff @(posedge clk) begin
		dsq_s3 <= dsq_c;
		phi_s4 <= PHI_W'(dsq_s3[DSQ_W-1:16]) * PHI_W'(hiv);
		plo_s4 <= PLO_W'(dsq_s3[15:0]) * PLO_W'(hiv);
		in_s4  <= THRESH_W'(dsq_s3) <= thresh;
		rom_s5 <= EXP_ROM[t_c[18 -: EXP_AW]];
	end

	// Advance valid flags and accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			add_s5   <= 1'b0;
			win_s5   <= 1'b0;
			sum_q    <= '0;
			within_q <= '0;
		end else begin
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			add_s5 <= v_s4 && in_s4 && (t_c < T_LIMIT);
			win_s5 <= v_s4 && in_s4;
			if (start) begin
				sum_q    <= '0;
				within_q <= '0;
			end else begin
				if (add_s5)
					sum_q <= sum_q + SUM_W'(rom_s5);
				if (win_s5)
					within_q <= within_q + CNT_W'(1);
			end
		end
	end

	assign mo.busy = v_s3 || v_s4 || add_s5 || win_s5;
	assign mo.hits = within_q;
	assign mo.sum  = sum_q;

endmodule

@@ rtl/core/kde_div.sv @@
module kde_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [kde_pkg::PROD_W-1:0] dividend,
	input  logic [kde_pkg::CNT_W-1:0]  divisor,
	output kde_pkg::div_out_t          dvo
);
	import kde_pkg::*;

	localparam int STEP_W = $clog2(PROD_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [PROD_W-1:0] qd_q;
	logic [CNT_W:0]    rem_sh;
	logic              ge;

	// One quotient bit per cycle, restoring
	assign rem_sh = {rem_q, qd_q[PROD_W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(PROD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			qd_q  <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? CNT_W'(rem_sh - {1'b0, div_q}) : rem_sh[CNT_W-1:0];
			qd_q  <= {qd_q[PROD_W-2:0], ge};
		end
	end

	assign dvo.done = done_q;
	assign dvo.quot = qd_q;

endmodule

@@ rtl/core/gaussian_kernel_density_eval_core.sv @@
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_stall | op, coord_0..coord_3
// result  | out       | out_valid/out_stall | density, points_within, points_stored, status
// config  | in        | cfg_we              | cfg_index, cfg_data
//
// Load, clear, an unknown op and an empty query go from idle straight to the
// finish state. A query walks the point store one point per cycle over four
// coordinate lanes, then drains the pipeline, forms the scaling product,
// launches the 56-step divider, waits for it and finishes. Reset empties the
// store and loads register defaults. A stalled result stays in the output
// register while the next item is taken; the item after that waits, with its
// input stalled, until it leaves.
module gaussian_kernel_density_eval_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic signed [15:0]            coord_0,
	input  logic signed [15:0]            coord_1,
	input  logic signed [15:0]            coord_2,
	input  logic signed [15:0]            coord_3,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kde_pkg::DENS_W-1:0]    density,
	output logic [kde_pkg::CNT_W-1:0]     points_within,
	output logic [kde_pkg::CNT_W-1:0]     points_stored,
	output logic [kde_pkg::STAT_W-1:0]    status,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [kde_pkg::THRESH_W-1:0]  cfg_data
);
	import kde_pkg::*;

	state_t state_q, state_d;

	logic [DIMS_W-1:0]   dims_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [HIV_W-1:0]    hiv_q;
	logic [NORM_W-1:0]   norm_q;
	logic [DIMS_W-1:0]   eff_dims;

	logic [POINT_W-1:0]  mem [MAX_POINTS];
	logic [POINT_W-1:0]  rd_s1;
	logic [POINT_W-1:0]  qry_q;
	logic [POINT_W-1:0]  in_point;
	logic                v_s1;
	logic                v_s2;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    count_q;
	logic                accept;
	logic                last_idx;
	logic                out_free;

	lane_sq_t            sq_s2;
	merge_out_t          mo;
	div_out_t            dvo;
	logic [PROD_W-1:0]   prod_q;

	logic [DENS_W-1:0]   res_density_q;
	logic [CNT_W-1:0]    res_within_q;
	logic [CNT_W-1:0]    res_stored_q;
	logic [STAT_W-1:0]   res_status_q;
	logic                out_valid_q;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign in_point = {coord_3, coord_2, coord_1, coord_0};
	assign last_idx = {1'b0, idx_q} == count_q - CNT_W'(1);
	assign out_free = !out_valid_q || !out_stall;

	// Clamp the dimension count
	always_comb begin
		if (dims_q == '0)
			eff_dims = DIMS_W'(1);
		else if (dims_q > DIMS_W'(MAX_DIMS))
			eff_dims = DIMS_W'(MAX_DIMS);
		else
			eff_dims = dims_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q   <= DIMS_W'(1);
			thresh_q <= THRESH_W'(1048576);
			hiv_q    <= HIV_W'(32768);
			norm_q   <= NORM_W'(26145);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIMS:   dims_q   <= cfg_data[DIMS_W-1:0];
				REG_THRESH: thresh_q <= cfg_data;
				REG_HIV:    hiv_q    <= cfg_data[HIV_W-1:0];
				REG_NORM:   norm_q   <= cfg_data[NORM_W-1:0];
			endcase
		end
	end

	// Point store: append on load, read one point per walk cycle
	always_ff @(posedge clk) begin
		if (accept && op == OP_LOAD && count_q < CNT_W'(MAX_POINTS))
			mem[count_q[IDX_W-1:0]] <= in_point;
		rd_s1 <= mem[idx_q];
	end

	// Coordinate lanes
	for (genvar l = 0; l < NUM_COORDS; l++) begin : g_lane
		kde_lane u_lane (
			.clk   (clk),
			.en    (DIMS_W'(l) < eff_dims),
			.x     (qry_q[COORD_W*l +: COORD_W]),
			.p     (rd_s1[COORD_W*l +: COORD_W]),
			.sq_s2 (sq_s2[l])
		);
	end

	kde_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.v_s2   (v_s2),
		.sq_s2  (sq_s2),
		.thresh (thresh_q),
		.hiv    (hiv_q),
		.mo     (mo)
	);

	kde_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_LAUNCH),
		.dividend (prod_q),
		.divisor  (count_q),
		.dvo      (dvo)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_QUERY && count_q != '0)
						state_d = ST_WALK;
					else
						state_d = ST_FINISH;
				end
			end
			ST_WALK: begin
				if (last_idx)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !mo.busy)
					state_d = ST_SCALE;
			end
			ST_SCALE:  state_d = ST_LAUNCH;
			ST_LAUNCH: state_d = ST_DIV;
			ST_DIV: begin
				if (dvo.done)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control: point count, walk index, valid flags, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_WALK;
			v_s2 <= v_s1;
			if (state_q == ST_WALK)
				idx_q <= idx_q + IDX_W'(1);
			if (accept) begin
				idx_q <= '0;
				if (op == OP_LOAD && count_q < CNT_W'(MAX_POINTS))
					count_q <= count_q + CNT_W'(1);
				else if (op == OP_CLEAR)
					count_q <= '0;
			end
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Result fields and the scaling product
	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q         <= in_point;
			res_density_q <= '0;
			res_within_q  <= '0;
			res_status_q  <= STAT_OK;
			res_stored_q  <= count_q;
			unique case (op)
				OP_LOAD: begin
					if (count_q < CNT_W'(MAX_POINTS))
						res_stored_q <= count_q + CNT_W'(1);
					else
						res_status_q <= STAT_FULL;
				end
				OP_QUERY: begin
					if (count_q == '0)
						res_status_q <= STAT_EMPTY;
				end
				OP_CLEAR: begin
					res_stored_q <= '0;
				end
				default: ;
			endcase
		end
		if (state_q == ST_SCALE)
			prod_q <= PROD_W'(mo.sum) * PROD_W'(norm_q);
		if (state_q == ST_DIV && dvo.done) begin
			res_density_q <= DENS_W'(dvo.quot[PROD_W-1:16]);
			res_within_q  <= mo.hits;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			density       <= res_density_q;
			points_within <= res_within_q;
			points_stored <= res_stored_q;
			status        <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
